// File: sv/pvp_pkg.sv
// ----------------------------------------------------------------------------
// Path velocity profiler package
// Shared constants and types for the path velocity profiler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pvp_pkg;

   localparam int LOOKAHEAD_DEF = 40;

   localparam logic [14:0] SPEED_LIMIT_RST = 15'd12800;
   localparam logic [14:0] START_SPEED_RST = 15'd0;
   localparam logic [14:0] END_SPEED_RST   = 15'd0;
   localparam logic [15:0] PATH_LENGTH_RST = 16'd1;

   localparam int DSU_REM_W  = 36;
   localparam int DSU_BITS_W = 64;
   localparam int DSU_Q_W    = 32;

   localparam logic [5:0] RAMP_ITERS = 6'd32;
   localparam logic [5:0] COMP_ITERS = 6'd30;
   localparam logic [5:0] ROOT_ITERS = 6'd15;

   typedef enum logic [1:0] {
      CSR_SPEED_LIMIT = 2'd0,
      CSR_START_SPEED = 2'd1,
      CSR_END_SPEED   = 2'd2,
      CSR_PATH_LENGTH = 2'd3
   } csr_index_type;

   typedef enum logic {
      DSU_DIV  = 1'b0,
      DSU_SQRT = 1'b1
   } dsu_op_type;

   typedef struct packed {
      logic       start;
      dsu_op_type op;
      logic [5:0] iters;
   } dsu_cmd_type;

endpackage

`default_nettype wire

// File: sv/pvp_ring.sv
// ----------------------------------------------------------------------------
// Path point ring
// Single-port-write, single-port-read memory holding recent path points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvp_ring #(
   parameter int DEPTH = 41,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/pvp_dsu.sv
// ----------------------------------------------------------------------------
// Divide and square root unit
// Shared restoring divider and digit-by-digit square root, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pvp_dsu (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pvp_pkg::dsu_cmd_type        cmd,
   input  wire logic [pvp_pkg::DSU_REM_W-1:0]  rem_init,
   input  wire logic [pvp_pkg::DSU_BITS_W-1:0] bits_init,
   input  wire logic [pvp_pkg::DSU_REM_W-1:0]  divisor,
   output logic [pvp_pkg::DSU_Q_W-1:0]      result,
   output logic                             done
);
   import pvp_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   dsu_op_type            op_ff, op_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [DSU_REM_W-1:0]  rem_ff, rem_in;
   logic [DSU_BITS_W-1:0] bits_ff, bits_in;
   logic [DSU_REM_W-1:0]  den_ff, den_in;
   logic [DSU_Q_W-1:0]    q_ff, q_in;
   logic [37:0]           cand;
   logic [37:0]           sub;
   logic [38:0]           diff;

   always_comb begin
      if (op_ff == DSU_SQRT) begin
         cand = {2'b00, rem_ff[33:0], bits_ff[63:62]};
         sub  = {4'b0000, q_ff, 2'b01};
      end else begin
         cand = {1'b0, rem_ff, bits_ff[63]};
         sub  = {2'b00, den_ff};
      end
      diff = {1'b0, cand} - {1'b0, sub};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (busy_ff) begin
         rem_in  = diff[38] ? cand[DSU_REM_W-1:0] : diff[DSU_REM_W-1:0];
         q_in    = {q_ff[DSU_Q_W-2:0], ~diff[38]};
         bits_in = (op_ff == DSU_SQRT) ? {bits_ff[61:0], 2'b00} : {bits_ff[62:0], 1'b0};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = cmd.iters;
         rem_in  = rem_init;
         bits_in = bits_init;
         den_in  = divisor;
         q_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
   end

   assign result = q_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

// File: sv/path_velocity_profiler.sv
// ----------------------------------------------------------------------------
// Path velocity profiler
// Emits a ramped, capped velocity along the path for each lagging path point.
// ----------------------------------------------------------------------------
// An item that causes no result leaves the block idle. Each result uses one ramp
// division (32 steps), then per component one division (30 steps) and one
// square root (15 steps) on the shared divide/root unit.
// A final point causes up to LOOKAHEAD+1 results, back to back.
// Reset is synchronous and active high; it restores the register defaults and
// clears the point count; the point ring is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module path_velocity_profiler #(
   parameter int LOOKAHEAD = pvp_pkg::LOOKAHEAD_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // point_x, point_y
   input  wire logic        req_tlast,   // final_point
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // vel_x, vel_y, point_index
   output logic             rsp_tlast,   // run_end
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import pvp_pkg::*;

   localparam int DEPTH = LOOKAHEAD + 1;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [18:0] {
      ST_IDLE   = 19'b0000000000000000001,
      ST_PRD    = 19'b0000000000000000010,
      ST_PAIM   = 19'b0000000000000000100,
      ST_FAIM   = 19'b0000000000000001000,
      ST_TRD    = 19'b0000000000000010000,
      ST_DXY    = 19'b0000000000000100000,
      ST_SQX    = 19'b0000000000001000000,
      ST_SQY    = 19'b0000000000010000000,
      ST_RMUL   = 19'b0000000000100000000,
      ST_RDIV   = 19'b0000000001000000000,
      ST_RWAIT  = 19'b0000000010000000000,
      ST_VSQ    = 19'b0000000100000000000,
      ST_MSQ    = 19'b0000001000000000000,
      ST_PLO    = 19'b0000010000000000000,
      ST_PHI    = 19'b0000100000000000000,
      ST_CSTART = 19'b0001000000000000000,
      ST_CDIV   = 19'b0010000000000000000,
      ST_CSQ    = 19'b0100000000000000000,
      ST_OUT    = 19'b1000000000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [14:0]          speed_limit_ff, start_speed_ff, end_speed_ff;
   logic [15:0]          path_length_ff;
   logic [15:0]          points_seen_ff, points_seen_in;
   logic [15:0]          emit_index_ff, emit_index_in;
   logic [AW-1:0]        wr_pos_ff, wr_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [47:0]          rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 fin_ff, fin_in;
   logic                 flush_ff, flush_in;
   logic                 comp_y_ff, comp_y_in;
   logic                 neg_ff, neg_in;
   logic [AW-1:0]        cur_age_ff, cur_age_in;
   logic [AW-1:0]        top_ff, top_in;
   logic signed [15:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic signed [16:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic signed [17:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [35:0]          acc_ff, acc_in;
   logic [35:0]          s_ff, s_in;
   logic [14:0]          v_ff, v_in;
   logic [29:0]          v2_ff, v2_in;
   logic [33:0]          mag2_ff, mag2_in;
   logic [46:0]          lo_ff, lo_in;
   logic signed [15:0]   vx_ff, vx_in, vy_ff, vy_in;

   logic signed [32:0]   mul_a;
   logic signed [17:0]   mul_b;
   logic signed [50:0]   prod_ff;

   logic                 req_fire;
   logic [AW-1:0]        rd_age;
   logic [AW:0]          slot_sum;
   logic [AW-1:0]        rd_addr;
   logic [31:0]          rd_data;
   logic signed [18:0]   dx_full, dy_full;
   logic signed [17:0]   dcur;
   logic [16:0]          mag;
   logic signed [15:0]   speed_diff;
   logic [31:0]          abs_num;
   logic signed [33:0]   ramp_sum;
   logic [63:0]          m_full;
   logic signed [15:0]   comp_val;
   logic                 out_last;

   dsu_cmd_type          dsu_cmd;
   logic [DSU_REM_W-1:0] dsu_rem;
   logic [DSU_BITS_W-1:0] dsu_bits;
   logic [DSU_REM_W-1:0] dsu_den;
   logic [DSU_Q_W-1:0]   dsu_result;
   logic                 dsu_done;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // Ring slot of a point of a given age, age zero being the newest.
   assign rd_age   = (state_ff == ST_PRD) ? AW'(1) : cur_age_ff;
   assign slot_sum = {1'b0, wr_pos_ff} + (AW + 1)'(DEPTH - 1) - {1'b0, rd_age};
   assign rd_addr  = (slot_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(slot_sum - (AW + 1)'(DEPTH)) : slot_sum[AW-1:0];

   pvp_ring #(.DEPTH(DEPTH), .AW(AW)) u_ring (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (wr_pos_ff),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pvp_dsu u_dsu (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dsu_cmd),
      .rem_init  (dsu_rem),
      .bits_init (dsu_bits),
      .divisor   (dsu_den),
      .result    (dsu_result),
      .done      (dsu_done)
   );

   assign dx_full  = {{2{ax_ff[16]}}, ax_ff} - {{2{rd_data[15]}}, rd_data[15:0], 1'b0};
   assign dy_full  = {{2{ay_ff[16]}}, ay_ff} - {{2{rd_data[31]}}, rd_data[31:16], 1'b0};
   assign dcur     = comp_y_ff ? dy_ff : dx_ff;
   assign mag      = dcur[17] ? 17'(-dcur) : dcur[16:0];
   assign speed_diff = $signed({1'b0, end_speed_ff}) - $signed({1'b0, start_speed_ff});
   assign abs_num  = prod_ff[31] ? -prod_ff[31:0] : prod_ff[31:0];
   assign ramp_sum = $signed({19'd0, start_speed_ff}) +
                     (neg_ff ? -$signed({2'b00, dsu_result}) : $signed({2'b00, dsu_result}));
   assign m_full   = {17'd0, lo_ff} + {prod_ff[46:0], 17'd0};
   assign comp_val = dcur[17] ? -$signed({1'b0, dsu_result[14:0]}) :
                     $signed({1'b0, dsu_result[14:0]});
   assign out_last = flush_ff ? (cur_age_ff == '0) : !fin_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQX: begin
            mul_a = {{15{dx_ff[17]}}, dx_ff};
            mul_b = dx_ff;
         end
         ST_SQY: begin
            mul_a = {{15{dy_ff[17]}}, dy_ff};
            mul_b = dy_ff;
         end
         ST_RMUL: begin
            mul_a = {{17{speed_diff[15]}}, speed_diff};
            mul_b = {2'b00, emit_index_ff};
         end
         ST_VSQ: begin
            mul_a = {18'd0, v_ff};
            mul_b = {3'd0, v_ff};
         end
         ST_MSQ: begin
            mul_a = {16'd0, mag};
            mul_b = {1'b0, mag};
         end
         ST_PLO: begin
            mul_a = {3'd0, v2_ff};
            mul_b = {1'b0, prod_ff[16:0]};
         end
         ST_PHI: begin
            mul_a = {3'd0, v2_ff};
            mul_b = {1'b0, mag2_ff[33:17]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      dsu_cmd  = '{start: 1'b0, op: DSU_DIV, iters: RAMP_ITERS};
      dsu_rem  = '0;
      dsu_bits = {abs_num, 32'd0};
      dsu_den  = (path_length_ff == '0) ? 36'd1 : {20'd0, path_length_ff};
      unique case (state_ff)
         ST_RDIV: begin
            dsu_cmd.start = 1'b1;
         end
         ST_CSTART: begin
            dsu_cmd  = '{start: 1'b1, op: DSU_DIV, iters: COMP_ITERS};
            dsu_rem  = {2'b00, m_full[63:30]};
            dsu_bits = {m_full[29:0], 34'd0};
            dsu_den  = s_ff;
         end
         ST_CDIV: begin
            dsu_cmd  = '{start: dsu_done, op: DSU_SQRT, iters: ROOT_ITERS};
            dsu_bits = {dsu_result[29:0], 34'd0};
         end
         default: begin
            dsu_cmd.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      points_seen_in = points_seen_ff;
      emit_index_in  = emit_index_ff;
      wr_pos_in      = wr_pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      fin_in         = fin_ff;
      flush_in       = flush_ff;
      comp_y_in      = comp_y_ff;
      neg_in         = neg_ff;
      cur_age_in     = cur_age_ff;
      top_in         = top_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      acc_in         = acc_ff;
      s_in           = s_ff;
      v_in           = v_ff;
      v2_in          = v2_ff;
      mag2_in        = mag2_ff;
      lo_in          = lo_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               nx_in          = req_tdata[15:0];
               ny_in          = req_tdata[31:16];
               fin_in         = req_tlast;
               flush_in       = 1'b0;
               wr_pos_in      = (wr_pos_ff == AW'(DEPTH - 1)) ? '0 : wr_pos_ff + AW'(1);
               points_seen_in = req_tlast ? '0 :
                                (points_seen_ff == 16'hFFFF) ? points_seen_ff :
                                points_seen_ff + 16'd1;
               top_in         = (points_seen_ff < 16'(LOOKAHEAD - 1)) ?
                                points_seen_ff[AW-1:0] : AW'(LOOKAHEAD - 1);
               if (points_seen_ff >= 16'(LOOKAHEAD)) begin
                  state_in = ST_PRD;
               end else if (req_tlast) begin
                  state_in = ST_FAIM;
               end
            end
         end
         ST_PRD: begin
            state_in = ST_PAIM;
         end
         ST_PAIM: begin
            ax_in      = 17'(nx_ff) + 17'($signed(rd_data[15:0]));
            ay_in      = 17'(ny_ff) + 17'($signed(rd_data[31:16]));
            cur_age_in = AW'(LOOKAHEAD);
            state_in   = ST_TRD;
         end
         ST_FAIM: begin
            ax_in      = {nx_ff, 1'b0};
            ay_in      = {ny_ff, 1'b0};
            cur_age_in = top_ff;
            flush_in   = 1'b1;
            state_in   = ST_TRD;
         end
         ST_TRD: begin
            state_in = ST_DXY;
         end
         ST_DXY: begin
            dx_in    = dx_full[17:0];
            dy_in    = dy_full[17:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = prod_ff[35:0];
            state_in = ST_RMUL;
         end
         ST_RMUL: begin
            s_in     = acc_ff + prod_ff[35:0];
            state_in = ST_RDIV;
         end
         ST_RDIV: begin
            neg_in   = prod_ff[31];
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (dsu_done) begin
               if (ramp_sum[33]) begin
                  v_in = '0;
               end else if (ramp_sum > $signed({19'd0, speed_limit_ff})) begin
                  v_in = speed_limit_ff;
               end else begin
                  v_in = ramp_sum[14:0];
               end
               comp_y_in = 1'b0;
               if (s_ff == '0) begin
                  vx_in    = $signed({1'b0, v_in});
                  vy_in    = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_VSQ;
               end
            end
         end
         ST_VSQ: begin
            state_in = ST_MSQ;
         end
         ST_MSQ: begin
            v2_in    = prod_ff[29:0];
            state_in = ST_PLO;
         end
         ST_PLO: begin
            mag2_in  = prod_ff[33:0];
            state_in = ST_PHI;
         end
         ST_PHI: begin
            lo_in    = prod_ff[46:0];
            state_in = ST_CSTART;
         end
         ST_CSTART: begin
            state_in = ST_CDIV;
         end
         ST_CDIV: begin
            if (dsu_done) begin
               state_in = ST_CSQ;
            end
         end
         ST_CSQ: begin
            if (dsu_done) begin
               if (comp_y_ff) begin
                  vy_in    = comp_val;
                  state_in = ST_OUT;
               end else begin
                  vx_in     = comp_val;
                  comp_y_in = 1'b1;
                  state_in  = ST_VSQ;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {emit_index_ff, vy_ff, vx_ff};
               rsp_last_in   = out_last;
               emit_index_in = (emit_index_ff == 16'hFFFF) ? emit_index_ff :
                               emit_index_ff + 16'd1;
               if (out_last) begin
                  state_in = ST_IDLE;
                  if (fin_ff) begin
                     emit_index_in = '0;
                  end
               end else if (!flush_ff) begin
                  state_in = ST_FAIM;
               end else begin
                  cur_age_in = cur_age_ff - AW'(1);
                  state_in   = ST_TRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         points_seen_ff <= '0;
         emit_index_ff  <= '0;
         wr_pos_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         speed_limit_ff <= SPEED_LIMIT_RST;
         start_speed_ff <= START_SPEED_RST;
         end_speed_ff   <= END_SPEED_RST;
         path_length_ff <= PATH_LENGTH_RST;
      end else begin
         state_ff       <= state_in;
         points_seen_ff <= points_seen_in;
         emit_index_ff  <= emit_index_in;
         wr_pos_ff      <= wr_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_SPEED_LIMIT: speed_limit_ff <= csr_data[14:0];
               CSR_START_SPEED: start_speed_ff <= csr_data[14:0];
               CSR_END_SPEED:   end_speed_ff   <= csr_data[14:0];
               CSR_PATH_LENGTH: path_length_ff <= csr_data;
            endcase
         end
      end
      prod_ff     <= mul_a * mul_b;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      fin_ff      <= fin_in;
      flush_ff    <= flush_in;
      comp_y_ff   <= comp_y_in;
      neg_ff      <= neg_in;
      cur_age_ff  <= cur_age_in;
      top_ff      <= top_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      acc_ff      <= acc_in;
      s_ff        <= s_in;
      v_ff        <= v_in;
      v2_ff       <= v2_in;
      mag2_ff     <= mag2_in;
      lo_ff       <= lo_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      dsu_done |-> (state_ff == ST_RWAIT || state_ff == ST_CDIV || state_ff == ST_CSQ))
      else $error("divide/root unit finished outside a wait state");

   a_quiet_point: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tlast && points_seen_ff < 16'(LOOKAHEAD)) |=> state_ff == ST_IDLE)
      else $error("point without results did not return to idle");

   a_age_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRD) |-> (cur_age_ff <= AW'(LOOKAHEAD)))
      else $error("ring age beyond lookahead");

   a_flush_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && fin_ff && out_last && (!rsp_valid_ff || rsp_tready))
      |=> emit_index_ff == '0)
      else $error("point index not cleared at path end");

endmodule

`default_nettype wire
